[rtl/core/lpr_pkg.sv]
// shared widths, word layouts and structs for the line pixel rasteriser
package lpr_pkg;

    localparam int COORD_BITS = 16;
    localparam int CW         = COORD_BITS;
    localparam int PW         = COORD_BITS - 1;
    localparam int EW         = COORD_BITS + 1;

    localparam int IN_RAW_W   = 8 + 4 * CW + 32;
    localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = 2 * PW + 32 + 7;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic ST_PIXEL  = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic signed [7:0]    window;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic [31:0]          color;
    } t_item;

    typedef struct packed {
        logic          status;
        logic [PW-1:0] pixel_x;
        logic [PW-1:0] pixel_y;
        logic [31:0]   pixel_color;
        logic [6:0]    pixel_window;
        logic          last_pixel;
    } t_result;

    // handshake between the pipeline stages
    typedef struct packed {
        logic fire;
        logic res_valid;
    } t_ctrl;

endpackage

[rtl/core/lpr_in_stage.sv]
// input register: unpacks and holds one incoming word
module lpr_in_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [lpr_pkg::IN_DATA_W-1:0] i_data,
    input  logic                         i_user,
    input  logic                         i_advance,
    output logic                         o_valid,
    output lpr_pkg::t_item               o_item
);
    import lpr_pkg::*;

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_item.operation = i_user;
        n_item.window    = $signed(i_data[7:0]);
        n_item.start_x   = $signed(i_data[8 +: CW]);
        n_item.start_y   = $signed(i_data[8 + CW +: CW]);
        n_item.end_x     = $signed(i_data[8 + 2 * CW +: CW]);
        n_item.end_y     = $signed(i_data[8 + 3 * CW +: CW]);
        n_item.color     = i_data[8 + 4 * CW +: 32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/core/lpr_engine.sv]
// line state: a load word sets up the line, a tick word makes one error-term step
module lpr_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  lpr_pkg::t_item  i_item,
    output logic            o_res_valid,
    output lpr_pkg::t_result o_result
);
    import lpr_pkg::*;

    logic                 r_active;
    logic [PW-1:0]        r_col, r_row, r_goal_col, r_goal_row, r_dx;
    logic signed [CW-1:0] r_ndy;
    logic [1:0]           r_signs;
    logic signed [EW-1:0] r_err;
    logic [31:0]          r_color;
    logic [6:0]           r_win;

    logic                 n_active;
    logic [PW-1:0]        n_col, n_row, n_goal_col, n_goal_row, n_dx;
    logic signed [CW-1:0] n_ndy;
    logic [1:0]           n_signs;
    logic signed [EW-1:0] n_err;
    logic [31:0]          n_color;
    logic [6:0]           n_win;

    logic                 reject, last, col_step, row_step;
    logic [PW-1:0]        x0, y0, x1, y1, dy;
    logic signed [EW:0]   e2;
    logic signed [EW+1:0] err_sum;

    always_comb begin
        x0 = i_item.start_x[PW-1:0];
        y0 = i_item.start_y[PW-1:0];
        x1 = i_item.end_x[PW-1:0];
        y1 = i_item.end_y[PW-1:0];
        reject = i_item.window[7] | i_item.start_x[CW-1] | i_item.start_y[CW-1]
               | i_item.end_x[CW-1] | i_item.end_y[CW-1];
        dy = (y1 >= y0) ? (y1 - y0) : (y0 - y1);

        e2       = {r_err, 1'b0};
        col_step = e2 >= $signed({{2{r_ndy[CW-1]}}, r_ndy});
        row_step = e2 <= $signed({3'b000, r_dx});
        err_sum  = $signed({{2{r_err[EW-1]}}, r_err})
                 + (col_step ? $signed({{3{r_ndy[CW-1]}}, r_ndy}) : '0)
                 + (row_step ? $signed({4'b0000, r_dx}) : '0);

        n_active   = r_active;
        n_col      = r_col;
        n_row      = r_row;
        n_goal_col = r_goal_col;
        n_goal_row = r_goal_row;
        n_dx       = r_dx;
        n_ndy      = r_ndy;
        n_signs    = r_signs;
        n_err      = r_err;
        n_color    = r_color;
        n_win      = r_win;
        o_res_valid = 1'b0;
        o_result    = '0;

        if (i_item.operation == OP_LOAD) begin
            o_res_valid = 1'b1;
            if (reject) begin
                n_active            = 1'b0;
                o_result.status     = ST_REJECT;
                o_result.last_pixel = 1'b1;
            end else begin
                n_col      = x0;
                n_row      = y0;
                n_goal_col = x1;
                n_goal_row = y1;
                n_dx       = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
                n_ndy      = -$signed({1'b0, dy});
                n_signs    = {!(y0 < y1), !(x0 < x1)};
                n_err      = $signed({2'b00, n_dx}) - $signed({2'b00, dy});
                n_color    = i_item.color;
                n_win      = i_item.window[6:0];
            end
        end else if (r_active) begin
            o_res_valid = 1'b1;
            if (col_step) begin
                n_col = r_signs[0] ? (r_col - 1'b1) : (r_col + 1'b1);
            end
            if (row_step) begin
                n_row = r_signs[1] ? (r_row - 1'b1) : (r_row + 1'b1);
            end
            n_err = err_sum[EW-1:0];
        end

        last = (n_col == n_goal_col) && (n_row == n_goal_row);
        if (o_res_valid && !(i_item.operation == OP_LOAD && reject)) begin
            n_active              = !last;
            o_result.status       = ST_PIXEL;
            o_result.pixel_x      = n_col;
            o_result.pixel_y      = n_row;
            o_result.pixel_color  = n_color;
            o_result.pixel_window = n_win;
            o_result.last_pixel   = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_fire) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_goal_col <= n_goal_col;
            r_goal_row <= n_goal_row;
            r_dx       <= n_dx;
            r_ndy      <= n_ndy;
            r_signs    <= n_signs;
            r_err      <= n_err;
            r_color    <= n_color;
            r_win      <= n_win;
        end
    end

endmodule

[rtl/core/lpr_out_stage.sv]
// output register: holds a result word until the sink takes it
module lpr_out_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpr_pkg::t_ctrl                i_ctrl,
    input  lpr_pkg::t_result              i_result,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [lpr_pkg::OUT_DATA_W-1:0] o_data,
    output logic                          o_user,
    output logic                          o_last
);
    import lpr_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.fire && i_ctrl.res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire && i_ctrl.res_valid) begin
            r_res <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_user  = r_res.status;
    assign o_last  = r_res.last_pixel;
    assign o_data  = {{(OUT_DATA_W - OUT_RAW_W){1'b0}}, r_res.pixel_window,
                      r_res.pixel_color, r_res.pixel_y, r_res.pixel_x};

endmodule

[rtl/core/line_pixel_rasterizer.sv]
// line pixel rasteriser top level: input register, stepping engine, output register
// a result word is worked out by the engine from the input register and held in the output register
// throughput: one word per cycle while the output register has room, set by the error-term add and compares
//   that update the line state in the engine stage
// a tick while idle is consumed and gives no result word
// reset: i_rst_n synchronous, active low; clears both stage valids and the active line
module line_pixel_rasterizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input words
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // window[7:0], start_x, start_y, end_x, end_y (COORD_BITS each), color[31:0]
    input  logic [lpr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation: 0 load, 1 tick
    input  logic                           s_axis_tuser,
    // result words
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_x, pixel_y (COORD_BITS-1 each), pixel_color[31:0], pixel_window[6:0], zero pad
    output logic [lpr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status: 0 pixel, 1 rejected
    output logic                           m_axis_tuser,
    // last_pixel: end point or rejection
    output logic                           m_axis_tlast
);
    import lpr_pkg::*;

    logic    item_valid;
    t_item   item;
    t_result result;
    t_ctrl   ctrl;
    logic    fire;
    logic    res_valid;

    // the engine advances whenever it holds a word and the output register has room
    assign fire = item_valid && (!m_axis_tvalid || m_axis_tready);
    assign ctrl = '{fire: fire, res_valid: res_valid};

    lpr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_user    (s_axis_tuser),
        .i_advance (fire),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    // state update and pixel selection for one word
    lpr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    lpr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_result (result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_data   (m_axis_tdata),
        .o_user   (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

endmodule

[bench/testbench.sv]
// self-checking bench for the line pixel rasteriser: directed and random lines, idle and stall phases
module testbench;
    import lpr_pkg::*;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    localparam int MAX_COORD = (1 << PW) - 1;

    line_pixel_rasterizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // words waiting to be sent, pixels waiting to come out
    t_item   word_queue[$];
    t_result pending_pixels[$];
    t_item   cur_word;
    int      items_made   = 0;
    int      fails        = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      pressure_on  = 1'b0;
    bit      hold_done    = 1'b0;
    int      hold_left    = 0;

    // own copy of the line state
    bit                   line_on    = 1'b0;
    logic [PW-1:0]        col_now    = '0;
    logic [PW-1:0]        row_now    = '0;
    logic [PW-1:0]        goal_col   = '0;
    logic [PW-1:0]        goal_row   = '0;
    logic [PW-1:0]        dcol       = '0;
    logic signed [CW-1:0] ndrow      = '0;
    logic [1:0]           step_dir   = '0;
    logic signed [EW-1:0] err        = '0;
    logic [31:0]          line_colour = '0;
    logic [6:0]           line_win   = '0;

    function automatic t_result current_pixel();
        t_result r;
        r              = '0;
        r.status       = ST_PIXEL;
        r.pixel_x      = col_now;
        r.pixel_y      = row_now;
        r.pixel_color  = line_colour;
        r.pixel_window = line_win;
        r.last_pixel   = (col_now == goal_col) && (row_now == goal_row);
        return r;
    endfunction

    // work out the pixel, if any, that one accepted word gives
    task automatic rasterise_word(input t_item it);
        t_result r;
        int      x0, y0, x1, y1, e2;
        r = '0;
        if (it.operation == OP_LOAD) begin
            if (it.window[7] || it.start_x[CW-1] || it.start_y[CW-1] ||
                it.end_x[CW-1] || it.end_y[CW-1]) begin
                // any negative argument cancels the line
                line_on      = 1'b0;
                r.status     = ST_REJECT;
                r.last_pixel = 1'b1;
                pending_pixels.push_back(r);
            end else begin
                x0          = int'(it.start_x);
                y0          = int'(it.start_y);
                x1          = int'(it.end_x);
                y1          = int'(it.end_y);
                col_now     = x0[PW-1:0];
                row_now     = y0[PW-1:0];
                goal_col    = x1[PW-1:0];
                goal_row    = y1[PW-1:0];
                dcol        = PW'((x1 > x0) ? x1 - x0 : x0 - x1);
                ndrow       = CW'(-((y1 > y0) ? y1 - y0 : y0 - y1));
                step_dir    = {(y0 < y1) ? 1'b0 : 1'b1, (x0 < x1) ? 1'b0 : 1'b1};
                err         = EW'(int'(dcol) + int'(ndrow));
                line_colour = it.color;
                line_win    = it.window[6:0];
                r           = current_pixel();
                line_on     = !r.last_pixel;
                pending_pixels.push_back(r);
            end
        end else if (line_on) begin
            e2 = 2 * int'(err);
            if (e2 >= int'(ndrow)) begin
                err     = EW'(int'(err) + int'(ndrow));
                col_now = step_dir[0] ? col_now - 1'b1 : col_now + 1'b1;
            end
            if (e2 <= int'(dcol)) begin
                err     = EW'(int'(err) + int'(dcol));
                row_now = step_dir[1] ? row_now - 1'b1 : row_now + 1'b1;
            end
            r       = current_pixel();
            line_on = !r.last_pixel;
            pending_pixels.push_back(r);
        end
    endtask

    task automatic push_load(input logic [7:0] win, input int x0, input int y0,
                             input int x1, input int y1, input logic [31:0] colour);
        t_item it;
        it.operation = OP_LOAD;
        it.window    = win;
        it.start_x   = CW'(x0);
        it.start_y   = CW'(y0);
        it.end_x     = CW'(x1);
        it.end_y     = CW'(y1);
        it.color     = colour;
        word_queue.push_back(it);
        items_made++;
    endtask

    // tick with junk in the unused fields; live is clear when it is expected to be ignored
    task automatic push_tick(input bit live);
        t_item it;
        it.operation = OP_TICK;
        it.window    = 8'($urandom);
        it.start_x   = CW'($urandom);
        it.start_y   = CW'($urandom);
        it.end_x     = CW'($urandom);
        it.end_y     = CW'($urandom);
        it.color     = $urandom;
        word_queue.push_back(it);
        if (live)
            items_made++;
    endtask

    task automatic push_line(input logic [7:0] win, input int x0, input int y0,
                             input int x1, input int y1, input logic [31:0] colour,
                             input int ticks);
        int dx, dy, len;
        dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
        len = (dx > dy) ? dx : dy;
        push_load(win, x0, y0, x1, y1, colour);
        for (int i = 0; i < ticks; i++)
            push_tick(i < len);
    endtask

    task automatic queue_random_line();
        int mode, span, x0, y0, x1, y1, dx, dy, len, ticks;
        logic [7:0] win;
        mode = $urandom_range(99);
        if (mode < 8) begin
            // raw load fields, mostly rejected, with a stray tick or two
            win = 8'($urandom);
            x0  = $urandom;
            y0  = $urandom;
            x1  = $urandom;
            y1  = $urandom;
            if ($urandom_range(1)) begin
                win = 8'($urandom_range(127));
                x0  = $urandom_range(MAX_COORD);
                y0  = $urandom_range(MAX_COORD);
                x1  = x0;
                y1  = y0;
                case ($urandom_range(4))
                    0: win = 8'($urandom_range(255, 128));
                    1: x0  = $urandom_range(65535, 32768);
                    2: y0  = $urandom_range(65535, 32768);
                    3: x1  = $urandom_range(65535, 32768);
                    default: y1 = $urandom_range(65535, 32768);
                endcase
            end
            push_load(win, x0, y0, x1, y1, $urandom);
            for (int i = $urandom_range(2); i > 0; i--)
                push_tick(1'b0);
            return;
        end
        span = $urandom_range(99);
        span = (span < 70) ? 12 : (span < 97) ? 64 : 400;
        if (mode < 14) begin
            // lines hugging the edges of the coordinate range
            x0 = $urandom_range(1) ? $urandom_range(3) : MAX_COORD - $urandom_range(3);
            y0 = $urandom_range(1) ? $urandom_range(3) : MAX_COORD - $urandom_range(3);
        end else begin
            x0 = $urandom_range(MAX_COORD);
            y0 = $urandom_range(MAX_COORD);
        end
        dx = $urandom_range(2 * span) - span;
        dy = $urandom_range(2 * span) - span;
        x1 = x0 + dx;
        y1 = y0 + dy;
        if (x1 < 0 || x1 > MAX_COORD)
            x1 = x0 - dx;
        if (y1 < 0 || y1 > MAX_COORD)
            y1 = y0 - dy;
        dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
        len = (dx > dy) ? dx : dy;
        if (mode < 24)
            ticks = $urandom_range(len);      // cut short, the next load replaces it
        else if (mode < 32)
            ticks = len + 1;                  // one tick after the end point
        else
            ticks = len;
        push_line(8'($urandom_range(127)), x0, y0, x1, y1, $urandom, ticks);
    endtask

    task automatic queue_directed();
        push_tick(1'b0);                                   // tick straight after reset
        push_load(8'h80, 1, 2, 3, 4, 32'h1234_5678);       // negative window
        push_load(8'd5, -32768, 2, 3, 4, $urandom);        // each coordinate negative
        push_load(8'd5, 1, -1, 3, 4, $urandom);
        push_load(8'd5, 1, 2, -1, 4, $urandom);
        push_load(8'd5, 1, 2, 3, -32768, $urandom);
        push_tick(1'b0);                                   // idle after a rejection
        push_line(8'd127, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);   // single point
        push_line(8'd0, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 32'h0, 0);
        push_line(8'd33, MAX_COORD, 0, MAX_COORD - 3, 2, $urandom, 3);
        push_tick(1'b0);
        push_line(8'd64, 0, MAX_COORD, 2, MAX_COORD - 5, $urandom, 2);  // replaced midway
        push_line(8'd1, 5, 5, 7, 5, $urandom, 2);          // horizontal
        push_line(8'd2, 7, 9, 7, 7, $urandom, 2);          // vertical
        push_line(8'd3, 3, 3, 1, 1, $urandom, 2);          // diagonal
    endtask

    // driver: offers the next queued word, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                rasterise_word(cur_word);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = word_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_word.color, cur_word.end_y, cur_word.end_x,
                                      cur_word.start_y, cur_word.start_x, cur_word.window};
                    s_axis_tuser  <= cur_word.operation;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once the pressure phase starts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (pressure_on && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // monitor: every accepted result word against the oldest expected pixel
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("result word with nothing expected: %0h", m_axis_tdata);
                fails++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("status", 32'(want.status), 32'(m_axis_tuser));
                check_field("pixel_x", 32'(want.pixel_x), 32'(m_axis_tdata[PW-1:0]));
                check_field("pixel_y", 32'(want.pixel_y), 32'(m_axis_tdata[2*PW-1:PW]));
                check_field("pixel_color", want.pixel_color, m_axis_tdata[2*PW+31:2*PW]);
                check_field("pixel_window", 32'(want.pixel_window),
                            32'(m_axis_tdata[2*PW+38:2*PW+32]));
                check_field("last_pixel", 32'(want.last_pixel), 32'(m_axis_tlast));
            end
        end
    end

    initial begin
        int target;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 5; ph++) begin
            @(negedge i_clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                3: begin send_idle_pct = 34; recv_stall_pct = 34; end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    pressure_on    = 1'b1;
                end
            endcase
            target = items_made + 350;
            if (ph == 0)
                queue_directed();
            while (items_made < target)
                queue_random_line();
            while (word_queue.size() != 0)
                @(negedge i_clk);
        end
        while (word_queue.size() != 0 || s_axis_tvalid || pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
